FILE: hdl/prc_pkg.sv
`timescale 1ns / 1ps

package prc_pkg;

  // CRC-16 definition: polynomial 0x8005, MSB first, no reflection, no final XOR.
  localparam logic [15:0] CrcPoly = 16'h8005;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam int unsigned WordW = 32;
  localparam int unsigned CrcW = 16;
  localparam int unsigned CountW = 6;

  // Result status codes.
  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusVersion = 2'd1;
  localparam logic [1:0] StatusCrc     = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CfgIdxCovered = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxVersion = 4'd1;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [WordW-1:0]  expected_version;
  } prc_cfg_t;

  // Bit-serial reference update, only evaluated at elaboration to build the columns.
  function automatic logic [CrcW-1:0] crc_serial(logic [CrcW-1:0] crc_in,
                                                 logic [WordW-1:0] word_in);
    logic [CrcW-1:0]  c;
    logic [WordW-1:0] w;
    logic             fb;
    c = crc_in;
    w = word_in;
    for (int b = 0; b < WordW; b++) begin
      fb = c[CrcW-1] ^ w[WordW-1];
      c  = {c[CrcW-2:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
      w = {w[WordW-2:0], 1'b0};
    end
    return c;
  endfunction

  // Contribution of each word bit to the updated CRC.
  function automatic logic [WordW-1:0][CrcW-1:0] word_columns();
    logic [WordW-1:0][CrcW-1:0] cols;
    for (int b = 0; b < WordW; b++) begin
      cols[b] = crc_serial('0, WordW'(1) << b);
    end
    return cols;
  endfunction

  // Contribution of each bit of the previous CRC to the updated CRC.
  function automatic logic [CrcW-1:0][CrcW-1:0] crc_columns();
    logic [CrcW-1:0][CrcW-1:0] cols;
    for (int j = 0; j < CrcW; j++) begin
      cols[j] = crc_serial(CrcW'(1) << j, '0);
    end
    return cols;
  endfunction

  localparam logic [WordW-1:0][CrcW-1:0] WordCols = word_columns();
  localparam logic [CrcW-1:0][CrcW-1:0]  CrcCols  = crc_columns();

  // One 32-bit CRC step as a flat XOR network over the precomputed columns.
  function automatic logic [CrcW-1:0] crc_next(logic [CrcW-1:0] crc_in,
                                               logic [WordW-1:0] word_in);
    logic [CrcW-1:0] acc;
    acc = '0;
    for (int b = 0; b < WordW; b++) begin
      acc = acc ^ ({CrcW{word_in[b]}} & WordCols[b]);
    end
    for (int j = 0; j < CrcW; j++) begin
      acc = acc ^ ({CrcW{crc_in[j]}} & CrcCols[j]);
    end
    return acc;
  endfunction

endpackage

FILE: hdl/prc_cfg.sv
`timescale 1ns / 1ps

module prc_cfg #(
  parameter int unsigned MAX_WORDS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [prc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [prc_pkg::WordW-1:0]      cfg_data_i,
  output prc_pkg::prc_cfg_t              cfg_o
);

  localparam logic [prc_pkg::CountW-1:0] MaxCount = prc_pkg::CountW'(MAX_WORDS - 1);

  logic [prc_pkg::CountW-1:0] covered_q;
  logic [prc_pkg::WordW-1:0]  version_q;
  logic                       wr_en;

  // The register file always takes a word.
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i && cfg_ready_o;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      covered_q <= prc_pkg::CountW'(45);
      version_q <= prc_pkg::WordW'(1);
    end else if (wr_en) begin
      unique case (cfg_index_i)
        prc_pkg::CfgIdxCovered: covered_q <= cfg_data_i[prc_pkg::CountW-1:0];
        prc_pkg::CfgIdxVersion: version_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective count: at least the version word, at most one word short of the record.
  always_comb begin
    cfg_o.expected_version = version_q;
    if (covered_q == '0) begin
      cfg_o.count = prc_pkg::CountW'(1);
    end else if (covered_q > MaxCount) begin
      cfg_o.count = MaxCount;
    end else begin
      cfg_o.count = covered_q;
    end
  end

endmodule

FILE: hdl/prc_core.sv
`timescale 1ns / 1ps

module prc_core #(
  parameter int unsigned MAX_WORDS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  prc_pkg::prc_cfg_t           cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [prc_pkg::WordW-1:0]   word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [prc_pkg::CrcW-1:0]    computed_crc_o
);

  localparam int unsigned PosW = (MAX_WORDS > 2) ? $clog2(MAX_WORDS) : 1;

  logic                       in_valid_q;
  logic [prc_pkg::WordW-1:0]  in_word_q;
  logic [prc_pkg::CrcW-1:0]   crc_q, crc_d;
  logic [PosW-1:0]            pos_q, pos_d;
  logic                       ver_bad_q, ver_bad_d;
  logic                       out_valid_q, out_valid_d;
  logic [1:0]                 status_q, status_d;
  logic [prc_pkg::CrcW-1:0]   out_crc_q;
  logic                       is_final;
  logic                       advance;
  logic                       in_take;

  // The word in the input register is the stored CRC word once the covered count is reached.
  assign is_final   = prc_pkg::CountW'(pos_q) >= cfg_i.count;
  assign advance    = in_valid_q && (!is_final || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= word_i;
    end
  end

  // Record state update and result formation.
  always_comb begin
    crc_d     = crc_q;
    pos_d     = pos_q;
    ver_bad_d = ver_bad_q;
    status_d  = status_q;
    if (advance) begin
      if (!is_final) begin
        if (pos_q == '0) begin
          ver_bad_d = in_word_q != cfg_i.expected_version;
        end
        crc_d = prc_pkg::crc_next(crc_q, in_word_q);
        pos_d = pos_q + PosW'(1);
      end else begin
        if (ver_bad_q) begin
          status_d = prc_pkg::StatusVersion;
        end else if (in_word_q[prc_pkg::CrcW-1:0] != crc_q) begin
          status_d = prc_pkg::StatusCrc;
        end else begin
          status_d = prc_pkg::StatusOk;
        end
        crc_d     = prc_pkg::CrcInit;
        pos_d     = '0;
        ver_bad_d = 1'b0;
      end
    end
  end

  // Output register valid: set by a finished record, cleared when the word is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && is_final) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= prc_pkg::CrcInit;
      pos_q       <= '0;
      ver_bad_q   <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= prc_pkg::StatusOk;
    end else begin
      crc_q       <= crc_d;
      pos_q       <= pos_d;
      ver_bad_q   <= ver_bad_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_final) begin
      out_crc_q <= crc_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign computed_crc_o = out_crc_q;

  // A finished record always shows a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && is_final |=> out_valid_q)
    else $error("finished record gave no result");

  // A bad version word wins over a CRC mismatch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && is_final && ver_bad_q |=> status_q == prc_pkg::StatusVersion)
    else $error("version mismatch not reported");

  // Record state restarts after the CRC word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && is_final |=> pos_q == '0 && crc_q == prc_pkg::CrcInit && !ver_bad_q)
    else $error("record state not restarted");

  // The status code is always one of the three defined codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (status_q == prc_pkg::StatusOk || status_q == prc_pkg::StatusVersion ||
                     status_q == prc_pkg::StatusCrc))
    else $error("undefined status code");

endmodule

FILE: hdl/param_record_crc_checker.sv
`timescale 1ns / 1ps
// A word accepted into the input register is processed from there; the result for a record
// is registered in the output register when its CRC word leaves the input register.
// Throughput: one word per cycle except as below; the 32-bit CRC update is one XOR network per word.
// A CRC word waits in the input register only while an earlier result is held by stall.
// Reset (asynchronous, active low) empties both registers, sets the CRC to 0xFFFF, restarts
// the record at word 0 and loads 45 covered words and expected version 1.
module param_record_crc_checker #(
  parameter int unsigned MAX_WORDS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [prc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [prc_pkg::WordW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [prc_pkg::WordW-1:0]    word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [prc_pkg::CrcW-1:0]     computed_crc_o
);

  prc_pkg::prc_cfg_t cfg;

  // Configuration registers.
  prc_cfg #(
    .MAX_WORDS (MAX_WORDS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Word datapath and record tracking.
  prc_core #(
    .MAX_WORDS (MAX_WORDS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .word_i         (word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .computed_crc_o (computed_crc_o)
  );

endmodule
